FILE: src/nstw_pkg.sv
// Package for the number-to-word-token block: beat types, token codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package nstw_pkg;

  localparam int unsigned TokW  = 6;
  localparam int unsigned DigN  = 10;
  localparam int unsigned BinW  = 32;
  localparam int unsigned CntW  = 5;

  localparam logic [TokW-1:0] TOK_TENS    = 6'd20;
  localparam logic [TokW-1:0] TOK_ORD     = 6'd28;
  localparam logic [TokW-1:0] TOK_ORDTENS = 6'd48;
  localparam logic [TokW-1:0] TOK_MINUS   = 6'd56;
  localparam logic [TokW-1:0] TOK_INFIN   = 6'd57;
  localparam logic [TokW-1:0] TOK_BILLION = 6'd58;
  localparam logic [TokW-1:0] TOK_MILLION = 6'd59;
  localparam logic [TokW-1:0] TOK_THOUS   = 6'd60;
  localparam logic [TokW-1:0] TOK_HUNDRED = 6'd61;
  localparam logic [TokW-1:0] TOK_AND     = 6'd62;

  // digit groups: billions, millions, thousands, low three digits
  localparam logic [1:0] GRP_BIL = 2'd0;
  localparam logic [1:0] GRP_MIL = 2'd1;
  localparam logic [1:0] GRP_THO = 2'd2;
  localparam logic [1:0] GRP_LOW = 2'd3;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] number;
  } in_t;

  typedef struct packed {
    logic [TokW-1:0] word_token;
    logic            last_word;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_START,
    ST_INF,
    ST_GRP,
    ST_HUND,
    ST_TENS,
    ST_UNITS,
    ST_SCALE,
    ST_AND,
    ST_FLUSH
  } state_e;

  typedef enum logic [2:0] {
    TS_MINUS,
    TS_INFIN,
    TS_HUNDW,
    TS_HUNDRED,
    TS_TENS,
    TS_UNITS,
    TS_SCALE,
    TS_AND
  } tok_sel_e;

  typedef struct packed {
    logic       load;
    logic       conv;
    logic       emit;
    logic       flush;
    tok_sel_e   tok;
    logic [1:0] grp;
  } dp_cmd_t;

  typedef struct packed {
    logic       conv_last;
    logic       neg;
    logic       minval;
    logic       go;
    logic [4:0] h;
    logic [3:0] t;
    logic [3:0] u;
    logic       grp_nz;
    logic       rest_zero;
    logic       rest_lt100;
  } dp_sts_t;

endpackage

FILE: src/number_to_spoken_word_tokens_core.sv
// Number to English word tokens, top level. Joins nstw_ctrl and nstw_dp.
// The first beat follows a 32-step serial BCD conversion of the accepted number.
// One number at a time: the next number is taken in the cycle after the final beat
// enters the output register.
// Reset (rst_ni, async, active low) clears the controller and the valid flags.
module number_to_spoken_word_tokens_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  nstw_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output nstw_pkg::out_t out_data_o
);
  import nstw_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  nstw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nstw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: src/nstw_dp.sv
// Datapath: serial binary-to-BCD conversion, digit group selection, token
// formation, one-token hold stage and output register.
// Depends on nstw_pkg.
module nstw_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nstw_pkg::dp_cmd_t cmd_i,
  output nstw_pkg::dp_sts_t sts_o,
  input  nstw_pkg::in_t    in_data_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output nstw_pkg::out_t   out_data_o
);
  import nstw_pkg::*;

  logic [BinW-1:0]   bin_q, bin_d;
  logic [4*DigN-1:0] bcd_q, bcd_d, bcd_adj;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              neg_q, neg_d, minv_q, minv_d, ord_q, ord_d;
  logic [TokW-1:0]   pend_q, pend_d;
  logic              pend_v_q, pend_v_d;
  out_t              out_q, out_d;
  logic              out_v_q, out_v_d;

  logic [BinW-1:0]   raw, mag;
  logic [3:0]        dig [DigN];
  logic [DigN-1:0]   z;
  logic              t_is1, t_ge2, thou;
  logic              ordx, out_free;
  logic [TokW-1:0]   tok, ubase;

  assign raw = BinW'(in_data_i.number);
  assign mag = raw[BinW-1] ? (~raw + BinW'(1)) : raw;

  always_comb begin
    for (int k = 0; k < DigN; k++) begin
      dig[k] = bcd_q[4*k +: 4];
      z[k]   = (dig[k] == 4'd0);
      bcd_adj[4*k +: 4] = (dig[k] >= 4'd5) ? (dig[k] + 4'd3) : dig[k];
    end
  end

  assign t_is1 = z[5] & z[4] & (dig[3] == 4'd1);
  assign t_ge2 = !z[5] | !z[4] | (dig[3] >= 4'd2);
  assign thou  = t_ge2 | (t_is1 & z[2]);

  always_comb begin
    sts_o            = '0;
    sts_o.conv_last  = (cnt_q == {CntW{1'b1}});
    sts_o.neg        = neg_q;
    sts_o.minval     = minv_q;
    out_free         = !out_v_q || !out_stall_i;
    sts_o.go         = !pend_v_q || out_free;
    unique case (cmd_i.grp)
      GRP_BIL: begin
        sts_o.u          = dig[9];
        sts_o.grp_nz     = !z[9];
        sts_o.rest_zero  = &z[8:0];
        sts_o.rest_lt100 = &z[8:2];
      end
      GRP_MIL: begin
        sts_o.h          = {1'b0, dig[8]};
        sts_o.t          = dig[7];
        sts_o.u          = dig[6];
        sts_o.grp_nz     = !(z[8] & z[7] & z[6]);
        sts_o.rest_zero  = &z[5:0];
        sts_o.rest_lt100 = &z[5:2];
      end
      GRP_THO: begin
        sts_o.h          = {1'b0, dig[5]};
        sts_o.t          = dig[4];
        sts_o.u          = dig[3];
        sts_o.grp_nz     = thou;
        sts_o.rest_zero  = &z[2:0];
        sts_o.rest_lt100 = z[2];
      end
      default: begin
        // eleven..nineteen hundred when the thousands group is not spoken
        sts_o.h      = (t_is1 && !z[2]) ? (5'd10 + {1'b0, dig[2]}) : {1'b0, dig[2]};
        sts_o.t      = dig[1];
        sts_o.u      = dig[0];
        sts_o.grp_nz = 1'b1;
      end
    endcase
  end

  assign ordx  = ord_q && (cmd_i.grp == GRP_LOW);
  assign ubase = (sts_o.t == 4'd1) ? (6'd10 + {2'b00, sts_o.u}) : {2'b00, sts_o.u};

  always_comb begin
    unique case (cmd_i.tok)
      TS_MINUS:   tok = TOK_MINUS;
      TS_INFIN:   tok = TOK_INFIN;
      TS_HUNDW:   tok = {1'b0, sts_o.h};
      TS_HUNDRED: tok = TOK_HUNDRED;
      TS_TENS:    tok = ((ordx && sts_o.u == 4'd0) ? TOK_ORDTENS : TOK_TENS)
                        + {2'b00, sts_o.t} - 6'd2;
      TS_UNITS:   tok = ordx ? (TOK_ORD + ubase) : ubase;
      TS_SCALE:   tok = TOK_BILLION + {4'b0000, cmd_i.grp};
      TS_AND:     tok = TOK_AND;
      default:    tok = TOK_AND;
    endcase
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    minv_d = minv_q;
    ord_d  = ord_q;
    if (cmd_i.load) begin
      bin_d  = mag;
      bcd_d  = '0;
      cnt_d  = '0;
      neg_d  = raw[BinW-1];
      minv_d = raw[BinW-1] && (raw[BinW-2:0] == '0);
      ord_d  = in_data_i.kind;
    end else if (cmd_i.conv) begin
      bcd_d = {bcd_adj[4*DigN-2:0], bin_q[BinW-1]};
      bin_d = {bin_q[BinW-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_comb begin
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && out_stall_i;
    if (cmd_i.flush) begin
      out_d    = '{word_token: pend_q, last_word: 1'b1};
      out_v_d  = 1'b1;
      pend_v_d = 1'b0;
    end else if (cmd_i.emit) begin
      pend_d   = tok;
      pend_v_d = 1'b1;
      if (pend_v_q) begin
        out_d   = '{word_token: pend_q, last_word: 1'b0};
        out_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    minv_q <= minv_d;
    ord_q  <= ord_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/nstw_ctrl.sv
// Controller: walks the digit groups and sequences the word tokens of one
// number. Issues commands to nstw_dp. Depends on nstw_pkg.
module nstw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  nstw_pkg::dp_sts_t sts_i,
  output nstw_pkg::dp_cmd_t cmd_o
);
  import nstw_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] grp_q, grp_d;
  state_e     grp_end;

  assign grp_end = (grp_q == GRP_LOW) ? ST_FLUSH : ST_SCALE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      grp_q   <= GRP_BIL;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    grp_d      = grp_q;
    in_stall_o = 1'b1;
    cmd_o      = '{load: 1'b0, conv: 1'b0, emit: 1'b0, flush: 1'b0,
                   tok: TS_UNITS, grp: grp_q};
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (sts_i.conv_last) state_d = ST_START;
      end
      ST_START: begin
        if (sts_i.go) begin
          grp_d = GRP_BIL;
          if (sts_i.neg) begin
            cmd_o.emit = 1'b1;
            cmd_o.tok  = TS_MINUS;
          end
          state_d = sts_i.minval ? ST_INF : ST_GRP;
        end
      end
      ST_INF: begin
        if (sts_i.go) begin
          cmd_o.emit = 1'b1;
          cmd_o.tok  = TS_INFIN;
          state_d    = ST_FLUSH;
        end
      end
      ST_GRP: begin
        if (!sts_i.grp_nz) begin
          grp_d = grp_q + 2'd1;
        end else if (sts_i.h != 5'd0) begin
          if (sts_i.go) begin
            cmd_o.emit = 1'b1;
            cmd_o.tok  = TS_HUNDW;
            state_d    = ST_HUND;
          end
        end else begin
          state_d = ST_TENS;
        end
      end
      ST_HUND: begin
        if (sts_i.go) begin
          cmd_o.emit = 1'b1;
          cmd_o.tok  = TS_HUNDRED;
          state_d    = (sts_i.t == 4'd0 && sts_i.u == 4'd0) ? grp_end : ST_TENS;
        end
      end
      ST_TENS: begin
        if (sts_i.go) begin
          cmd_o.emit = 1'b1;
          if (sts_i.t >= 4'd2) begin
            cmd_o.tok = TS_TENS;
            state_d   = (sts_i.u == 4'd0) ? grp_end : ST_UNITS;
          end else begin
            cmd_o.tok = TS_UNITS;
            state_d   = grp_end;
          end
        end
      end
      ST_UNITS: begin
        if (sts_i.go) begin
          cmd_o.emit = 1'b1;
          cmd_o.tok  = TS_UNITS;
          state_d    = grp_end;
        end
      end
      ST_SCALE: begin
        if (sts_i.go) begin
          cmd_o.emit = 1'b1;
          cmd_o.tok  = TS_SCALE;
          if (sts_i.rest_zero) begin
            state_d = ST_FLUSH;
          end else if (sts_i.rest_lt100) begin
            state_d = ST_AND;
          end else begin
            grp_d   = grp_q + 2'd1;
            state_d = ST_GRP;
          end
        end
      end
      ST_AND: begin
        if (sts_i.go) begin
          cmd_o.emit = 1'b1;
          cmd_o.tok  = TS_AND;
          grp_d      = grp_q + 2'd1;
          state_d    = ST_GRP;
        end
      end
      ST_FLUSH: begin
        if (sts_i.go) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: tb/sv/nstw_word_checker.sv
// Scoreboard for number_to_spoken_word_tokens_core: watches both channels,
// spells each accepted number into word tokens and checks the output beats.
// Depends on nstw_pkg for beat types and token codes.
`timescale 1ns / 100ps

module nstw_word_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  nstw_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  nstw_pkg::out_t out_data_i,
  output int             errors_o,
  output int             pending_o
);
  import nstw_pkg::*;

  localparam int unsigned     MaxWords      = 20;
  localparam int unsigned     ShownErrors   = 10;

  logic [TokW-1:0] spoken_words[$];
  out_t            expected_words[$];
  int              errors = 0;
  int unsigned     beat_cnt = 0;

  function automatic void add_word(input logic [TokW-1:0] w);
    if (spoken_words.size() < MaxWords) spoken_words.push_back(w);
  endfunction

  // hundreds, tens and units of a value below 2000
  function automatic void speak_below_2000(input int unsigned v, input logic ordinal);
    int unsigned rest;
    int unsigned tens;
    rest = v;
    if (rest >= 100) begin
      add_word(TokW'(rest / 100));
      add_word(TOK_HUNDRED);
      rest = rest % 100;
      if (rest == 0) return;
    end
    if (rest >= 20) begin
      tens = (rest - 20) / 10;
      if (ordinal && (rest % 10) == 0) begin
        add_word(TokW'(TOK_ORDTENS + tens));
        return;
      end
      add_word(TokW'(TOK_TENS + tens));
      rest = rest % 10;
      if (rest == 0) return;
    end
    add_word(ordinal ? TokW'(TOK_ORD + rest) : TokW'(rest));
  endfunction

  function automatic void spell_number(input logic ordinal, input logic [31:0] raw);
    logic [31:0]     mag;
    int unsigned     div;
    logic [TokW-1:0] scale;
    bit              hit;
    int              g;
    spoken_words.delete();
    mag = raw;
    if (raw[31]) begin
      add_word(TOK_MINUS);
      if (raw == 32'h8000_0000) begin
        add_word(TOK_INFIN);
        return;
      end
      mag = ~raw + 32'd1;
    end
    for (g = 0; g < 3; g++) begin
      case (g)
        0: begin
          div   = 1_000_000_000;
          scale = TOK_BILLION;
          hit   = mag >= div;
        end
        1: begin
          div   = 1_000_000;
          scale = TOK_MILLION;
          hit   = mag >= div;
        end
        default: begin
          div   = 1000;
          scale = TOK_THOUS;
          hit   = (mag >= 1000 && mag <= 1099) || mag >= 2000;
        end
      endcase
      if (hit) begin
        speak_below_2000(mag / div, 1'b0);
        mag = mag % div;
        add_word(scale);
        if (mag == 0) return;
        if (mag < 100) add_word(TOK_AND);
      end
    end
    speak_below_2000(mag, ordinal);
  endfunction

  always @(posedge clk_i) begin : watch
    out_t beat;
    int   i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        spell_number(in_data_i.kind, in_data_i.number);
        for (i = 0; i < spoken_words.size(); i++) begin
          beat.word_token = spoken_words[i];
          beat.last_word  = (i == spoken_words.size() - 1);
          expected_words.push_back(beat);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= ShownErrors)
            $display("%0t: beat %0d unexpected: token %0d last %0b", $time, beat_cnt,
                     out_data_i.word_token, out_data_i.last_word);
        end else begin
          beat = expected_words.pop_front();
          if (out_data_i.word_token !== beat.word_token ||
              out_data_i.last_word !== beat.last_word) begin
            errors++;
            if (errors <= ShownErrors)
              $display("%0t: beat %0d expected token %0d last %0b, got token %0d last %0b",
                       $time, beat_cnt, beat.word_token, beat.last_word,
                       out_data_i.word_token, out_data_i.last_word);
          end
        end
        beat_cnt++;
      end
      pending_o <= expected_words.size();
      errors_o  <= errors;
    end
  end

endmodule

FILE: tb/sv/number_to_spoken_word_tokens_core_tb.sv
// Testbench top for number_to_spoken_word_tokens_core: drives numbers with
// random idling and output stalls; nstw_word_checker scores the token beats.
// Depends on nstw_pkg, the core and nstw_word_checker.
`timescale 1ns / 100ps

module number_to_spoken_word_tokens_core_tb;
  import nstw_pkg::*;

  localparam int unsigned RandItems  = 176;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned DrainWait  = 100;
  localparam int unsigned CycleLimit = 600_000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_t         in_data   = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  out_t        out_data;
  int          errors;
  int          pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned cycles        = 0;
  logic        hold_go       = 1'b0;
  logic        hold_seen     = 1'b0;
  int unsigned hold_left     = 0;

  always #6 clk = ~clk;

  number_to_spoken_word_tokens_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  nstw_word_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_number(input logic k, input logic signed [31:0] n);
    in_t beat;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    beat.kind   = k;
    beat.number = n;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [31:0] pick_number();
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom();
      1: v = $urandom_range(2000);
      2: v = $urandom_range(999) * 1000 + $urandom_range(99);
      3: begin
        v = $urandom_range(1, 19);
        repeat ($urandom_range(1, 8)) v = v * 10;
      end
      4: v = $urandom_range(2) * 1_000_000_000 + $urandom_range(99);
      default: v = $urandom_range(999) * 1_000_000 + $urandom_range(99);
    endcase
    if ($urandom_range(3) == 0) v = ~v + 32'd1;
    return v;
  endfunction

  initial begin
    int p;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_number(1'b0, 0);
    send_number(1'b1, 0);
    send_number(1'b1, 1);
    send_number(1'b1, 7);
    send_number(1'b1, 13);
    send_number(1'b1, 19);
    send_number(1'b1, 20);
    send_number(1'b1, 21);
    send_number(1'b1, 90);
    send_number(1'b0, 99);
    send_number(1'b1, 100);
    send_number(1'b0, 105);
    send_number(1'b1, 1000);
    send_number(1'b1, 1001);
    send_number(1'b0, 1099);
    send_number(1'b1, 1100);
    send_number(1'b1, 1999);
    send_number(1'b1, 2000);
    send_number(1'b1, 1_000_000);
    send_number(1'b1, 1_000_050);
    send_number(1'b0, 2_000_000_000);
    send_number(1'b1, 32'h7FFF_FFFF);
    send_number(1'b0, 32'h8000_0000);
    send_number(1'b1, -1);
    send_number(1'b1, -1_777_777_777);

    // long output hold while input keeps coming: core fills and stalls input
    hold_go <= ~hold_go;
    repeat (8) send_number($urandom_range(1) != 0, pick_number());

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 55;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 55;
        end
        default: begin
          send_idle_pct = 17;
          stall_pct     = 17;
        end
      endcase
      repeat (RandItems / 4) send_number($urandom_range(1) != 0, pick_number());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: number_to_spoken_word_tokens_core.f
src/nstw_pkg.sv
src/nstw_dp.sv
src/nstw_ctrl.sv
src/number_to_spoken_word_tokens_core.sv
tb/sv/nstw_word_checker.sv
tb/sv/number_to_spoken_word_tokens_core_tb.sv
